// ----- hdl/light_flicker_intensity_core_assert.svh -----
// ----------------------------------------------------------------------------
// Light flicker intensity core - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIGHT_FLICKER_INTENSITY_CORE_ASSERT_SVH
`define LIGHT_FLICKER_INTENSITY_CORE_ASSERT_SVH

// Same-cycle implication
`define LFI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LFI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lfi_pkg.sv -----
// ----------------------------------------------------------------------------
// lfi_pkg
// Types, constants, sine table and divider step for the flicker intensity core.
// ----------------------------------------------------------------------------
package lfi_pkg;

  // Cycle position fraction and quarter-wave table size
  localparam int FRAC_W     = 16;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);

  // Cycle length 20*(period+1) fits in this width
  localparam int LEN_W = 13;

  localparam logic [15:0] Q15_ONE    = 16'd32768;
  localparam logic [15:0] Q15_HALF   = 16'd16384;
  // Largest position with 10*pos below 2^FRAC_W
  localparam logic [FRAC_W-1:0] STROBE_LIM = FRAC_W'(((1 << FRAC_W) - 1) / 10);

  // Pulse numerators with rounding offset
  localparam logic signed [19:0] PULSE_BASE  = 20'sd196613;
  localparam logic signed [19:0] SUBTLE_BASE = 20'sd294917;
  // Reciprocal of 10 scaled by 2^22, exact for numerators below 2^19
  localparam logic [18:0] DIV10_MUL = 19'd419431;
  localparam int          DIV10_SH  = 22;

  // Flicker hash constants
  localparam logic [30:0] FLICK_MUL = 31'd1315423911;
  localparam logic [63:0] FMIX_C1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2   = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [2:0] {
    FX_PULSE   = 3'd0,
    FX_SUBTLE  = 3'd1,
    FX_BLINK   = 3'd2,
    FX_STROBE  = 3'd3,
    FX_FLICKER = 3'd4,
    FX_STEADY  = 3'd5
  } effect_t;

  // Eight steps of restoring division
  typedef struct packed {
    logic [7:0]       q;
    logic [LEN_W-1:0] r;
  } div_t;

  function automatic div_t div8(logic [LEN_W-1:0] r_in, logic [7:0] bits,
                                logic [LEN_W-1:0] d);
    div_t           res;
    logic [LEN_W:0] t;
    logic [LEN_W-1:0] r;
    r = r_in;
    res.q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        res.q[i] = 1'b1;
      end
      r = t[LEN_W-1:0];
    end
    res.r = r;
    return res;
  endfunction

  // Quarter-wave sine table, Q15, built at elaboration from a Taylor series
  typedef logic [SINE_DEPTH-1:0][15:0] sine_rom_t;

  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] TWO_DEPTH  = 64'(2 * SINE_DEPTH);
  localparam logic [63:0] TAYLOR_DIV [1:10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420};

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int j = 0; j < SINE_DEPTH; j++) begin
      x    = (PI_Q30 * 64'(j)) / TWO_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
        sum = 64'sd32768;
      end
      rom[j] = sum[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- hdl/light_flicker_intensity_core.sv -----
// ----------------------------------------------------------------------------
// light_flicker_intensity_core
// Per-light intensity for pulse, subtle, blink, strobe, flicker and steady effects.
// ----------------------------------------------------------------------------
// Throughput: one query per cycle; each stage holds only while it is full and
//   the stage after it cannot take its contents.
// Cycle position is a 32+16 step restoring divider spread over six stages.
// Reset clears all valid bits; the core keeps no other state.
module light_flicker_intensity_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        query_valid,
  output logic        query_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  period,
  input  logic [7:0]  phase,
  input  logic [31:0] light_index,
  input  logic [31:0] time_ticks,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] intensity
);

  localparam int NSTAGE = 10;
  localparam int LW     = lfi_pkg::LEN_W;
  localparam int FW     = lfi_pkg::FRAC_W;
  localparam int AW     = lfi_pkg::SINE_AW;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // Stage payloads
  logic [LW-1:0]    len_0, len_1, len_2, len_3, len_4;
  logic [LW-1:0]    rem_0, rem_1, rem_2, rem_3, rem_4;
  logic [23:0]      tk_0;
  logic [15:0]      tk_1;
  logic [7:0]       tk_2;
  logic [7:0]       ph_0, ph_1, ph_2, ph_3, ph_4, ph_5;
  lfi_pkg::effect_t fn_0, fn_1, fn_2, fn_3, fn_4, fn_5, fn_6, fn_7, fn_8;
  logic [7:0]       qh_4;
  logic [FW-1:0]    qt_5;
  logic [FW-1:0]    pos_6;
  logic [15:0]      flick_5, flick_6, flick_7, flick_8;
  logic signed [16:0] sv_7;
  logic             blink_7, strobe_7, blink_8, strobe_8;
  logic [37:0]      prod_8;

  // Combinational per-stage work
  logic [LW-1:0]      len_in;
  lfi_pkg::div_t      d0, d1, d2, d3, d4, d5;
  logic [AW+1:0]      kq;
  logic [AW:0]        tab_ix;
  logic [16:0]        mag;
  logic signed [19:0] sx;
  logic signed [19:0] num;

  // Hold a stage while it is full and the next cannot take it
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || !result_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign query_stall  = !en[0];
  assign result_valid = vld[NSTAGE-1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= query_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Cycle length and divider steps
  always_comb begin
    len_in = (LW'(period) + LW'(1)) * LW'(20);
    d0 = lfi_pkg::div8('0, time_ticks[31:24], len_in);
    d1 = lfi_pkg::div8(rem_0, tk_0[23:16], len_0);
    d2 = lfi_pkg::div8(rem_1, tk_1[15:8], len_1);
    d3 = lfi_pkg::div8(rem_2, tk_2, len_2);
    d4 = lfi_pkg::div8(rem_3, 8'h00, len_3);
    d5 = lfi_pkg::div8(rem_4, 8'h00, len_4);
  end

  // Stages 0 to 3: ticks modulo cycle length
  always_ff @(posedge clk) begin
    if (en[0]) begin
      len_0 <= len_in;
      rem_0 <= d0.r;
      tk_0  <= time_ticks[23:0];
      ph_0  <= phase;
      fn_0  <= lfi_pkg::effect_t'(func);
    end
    if (en[1]) begin
      len_1 <= len_0;
      rem_1 <= d1.r;
      tk_1  <= tk_0[15:0];
      ph_1  <= ph_0;
      fn_1  <= fn_0;
    end
    if (en[2]) begin
      len_2 <= len_1;
      rem_2 <= d2.r;
      tk_2  <= tk_1[7:0];
      ph_2  <= ph_1;
      fn_2  <= fn_1;
    end
    if (en[3]) begin
      len_3 <= len_2;
      rem_3 <= d3.r;
      ph_3  <= ph_2;
      fn_3  <= fn_2;
    end
  end

  // Stages 4 and 5: fraction of the cycle
  always_ff @(posedge clk) begin
    if (en[4]) begin
      len_4 <= len_3;
      rem_4 <= d4.r;
      qh_4  <= d4.q;
      ph_4  <= ph_3;
      fn_4  <= fn_3;
    end
    if (en[5]) begin
      qt_5 <= {qh_4, d5.q};
      ph_5 <= ph_4;
      fn_5 <= fn_4;
    end
  end

  lfi_hash u_hash (
    .clk         (clk),
    .en          (en[5:0]),
    .light_index (light_index),
    .time_ticks  (time_ticks),
    .flick       (flick_5)
  );

  // Stage 6: add the phase offset
  always_ff @(posedge clk) begin
    if (en[6]) begin
      pos_6   <= qt_5 + FW'({ph_5, (FW - 8)'(0)});
      fn_6    <= fn_5;
      flick_6 <= flick_5;
    end
  end

  // Stage 7: quarter-wave lookup with quadrant folding
  always_comb begin
    kq     = pos_6[FW-1 -: AW+2];
    tab_ix = kq[AW] ? ((AW+1)'(lfi_pkg::SINE_DEPTH) - {1'b0, kq[AW-1:0]})
                    : {1'b0, kq[AW-1:0]};
    mag    = tab_ix[AW] ? 17'(lfi_pkg::Q15_ONE)
                        : {1'b0, lfi_pkg::SINE_ROM[tab_ix[AW-1:0]]};
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sv_7     <= kq[AW+1] ? -signed'(mag) : signed'(mag);
      blink_7  <= !pos_6[FW-1];
      strobe_7 <= (pos_6 <= lfi_pkg::STROBE_LIM);
      fn_7     <= fn_6;
      flick_7  <= flick_6;
    end
  end

  // Stage 8: scale the sine and divide by ten through the reciprocal
  always_comb begin
    sx  = 20'(sv_7);
    num = (fn_7 == lfi_pkg::FX_PULSE) ? (lfi_pkg::PULSE_BASE + (sx <<< 2))
                                      : (lfi_pkg::SUBTLE_BASE + sx);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      prod_8   <= 38'(num[18:0]) * 38'(lfi_pkg::DIV10_MUL);
      blink_8  <= blink_7;
      strobe_8 <= strobe_7;
      fn_8     <= fn_7;
      flick_8  <= flick_7;
    end
  end

  // Stage 9: select the effect into the output register
  always_ff @(posedge clk) begin
    if (en[9]) begin
      case (fn_8)
        lfi_pkg::FX_PULSE,
        lfi_pkg::FX_SUBTLE:  intensity <= 16'(prod_8 >> lfi_pkg::DIV10_SH);
        lfi_pkg::FX_BLINK:   intensity <= blink_8 ? lfi_pkg::Q15_ONE : 16'h0000;
        lfi_pkg::FX_STROBE:  intensity <= strobe_8 ? lfi_pkg::Q15_ONE : 16'h0000;
        lfi_pkg::FX_FLICKER: intensity <= flick_8;
        default:             intensity <= lfi_pkg::Q15_ONE;
      endcase
    end
  end

endmodule

// ----- hdl/lfi_hash.sv -----
// ----------------------------------------------------------------------------
// lfi_hash
// Six-stage flicker hash: step number times seed constant plus light index,
// then the 64-bit fmix finalizer with products split into 32-bit halves.
// ----------------------------------------------------------------------------
module lfi_hash (
  input  logic        clk,
  input  logic [5:0]  en,
  input  logic [31:0] light_index,
  input  logic [31:0] time_ticks,
  output logic [15:0] flick
);

  logic [57:0] m1;
  logic [31:0] idx1;
  logic [63:0] x2;
  logic [63:0] pa3;
  logic [31:0] pb3;
  logic [31:0] pc3;
  logic [63:0] z4;
  logic [63:0] pa5;
  logic [31:0] pb5;
  logic [31:0] pc5;

  logic [63:0] n_sum;
  logic [63:0] y_sum;
  logic [63:0] w_sum;
  logic [63:0] w_mix;
  logic [16:0] h_rnd;

  always_comb begin
    n_sum = 64'(m1) + 64'(idx1);
    y_sum = pa3 + {pb3 + pc3, 32'h0};
    w_sum = pa5 + {pb5 + pc5, 32'h0};
    w_mix = w_sum ^ (w_sum >> 33);
    h_rnd = 17'(w_mix[63:48]) + 17'd2;
  end

  // Multiply the step number (ticks divided by 32) by the seed constant
  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1   <= 58'(time_ticks[31:5]) * 58'(lfi_pkg::FLICK_MUL);
      idx1 <= light_index;
    end
  end

  // Add the index, first xor-shift
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x2 <= n_sum ^ (n_sum >> 33);
    end
  end

  // Partial products with the first constant
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pa3 <= 64'(x2[31:0]) * 64'(lfi_pkg::FMIX_C1[31:0]);
      pb3 <= 32'(x2[63:32] * lfi_pkg::FMIX_C1[31:0]);
      pc3 <= 32'(x2[31:0] * lfi_pkg::FMIX_C1[63:32]);
    end
  end

  // Combine, second xor-shift
  always_ff @(posedge clk) begin
    if (en[3]) begin
      z4 <= y_sum ^ (y_sum >> 33);
    end
  end

  // Partial products with the second constant
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pa5 <= 64'(z4[31:0]) * 64'(lfi_pkg::FMIX_C2[31:0]);
      pb5 <= 32'(z4[63:32] * lfi_pkg::FMIX_C2[31:0]);
      pc5 <= 32'(z4[31:0] * lfi_pkg::FMIX_C2[63:32]);
    end
  end

  // Final xor-shift, scale top 16 bits to 0.5..1.0
  always_ff @(posedge clk) begin
    if (en[5]) begin
      flick <= lfi_pkg::Q15_HALF + 16'(h_rnd[16:2]);
    end
  end

endmodule

// ----- hdl/lfi_checker.sv -----
// ----------------------------------------------------------------------------
// lfi_checker
// Port-level checks on the flicker intensity core, bound to the top level.
// ----------------------------------------------------------------------------
`include "light_flicker_intensity_core_assert.svh"

module lfi_checker (
  input logic        clk,
  input logic        rst,
  input logic        query_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] intensity
);

  // Hold a stalled result transaction
  `LFI_ASSERT_NXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
  `LFI_ASSERT_NXT(a_res_stable, result_valid && result_stall, $stable(intensity), "result changed while stalled")

  // Back-pressure only when a finished result is waiting
  `LFI_ASSERT_IMP(a_stall_full, query_stall, result_valid && result_stall, "query stalled with room in pipeline")

  // Intensity is zero or lies between the pulse floor and full
  `LFI_ASSERT_IMP(a_range, result_valid, (intensity == 16'd0) || ((intensity >= 16'd6553) && (intensity <= 16'd32768)), "intensity out of range")

endmodule

bind light_flicker_intensity_core lfi_checker u_lfi_checker (.*);

// ----- bench/light_flicker_intensity_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light flicker intensity core testbench
// Drives light queries through the core and compares each intensity against
// a predictor written here, with random gaps, stalls and a long hold-off.
// ----------------------------------------------------------------------------

// Holds predicted intensities in order and checks results against them
class intensity_board;
  logic [15:0] pending_q[$];
  int          errors;
  int          checked;
  logic [15:0] sine_tab[0:256];

  function new();
    logic [63:0] x, x2, term;
    longint sum;
    errors = 0;
    checked = 0;
    // Build the quarter-wave table from the Taylor series in Q30
    for (int j = 0; j < 256; j++) begin
      x = (64'd3373259426 * 64'(j)) / 64'd512;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) sum = 32768;
      sine_tab[j] = sum[15:0];
    end
    sine_tab[256] = 16'd32768;
  endfunction

  function automatic logic [63:0] mix64(logic [63:0] n);
    n ^= n >> 33;
    n *= 64'hff51afd7ed558ccd;
    n ^= n >> 33;
    n *= 64'hc4ceb9fe1a85ec53;
    n ^= n >> 33;
    return n;
  endfunction

  // Predict intensity of one query and queue it
  function void note_query(logic [2:0] fx, logic [7:0] per, logic [7:0] ph,
                           logic [31:0] idx, logic [31:0] ticks);
    logic [63:0] len, pos, k, n;
    int s, q, j, res;
    len = 64'd20 * (64'(per) + 1);
    pos = ((64'(ticks) % len) << 16) / len;
    pos = (pos + (64'(ph) << 8)) & 64'hffff;
    k = (pos * 1024) >> 16;
    q = int'(k / 256);
    j = int'(k % 256);
    case (q)
      0: s = sine_tab[j];
      1: s = sine_tab[256 - j];
      2: s = -int'(sine_tab[j]);
      default: s = -int'(sine_tab[256 - j]);
    endcase
    case (fx)
      lfi_pkg::FX_PULSE:   res = (6 * 32768 + 4 * s + 5) / 10;
      lfi_pkg::FX_SUBTLE:  res = (9 * 32768 + s + 5) / 10;
      lfi_pkg::FX_BLINK:   res = (pos < 64'd32768) ? 32768 : 0;
      lfi_pkg::FX_STROBE:  res = (pos * 10 < 64'd65536) ? 32768 : 0;
      lfi_pkg::FX_FLICKER: begin
        n = (64'(ticks) >> 5) * 64'd1315423911 + 64'(idx);
        res = 16384 + int'(((mix64(n) >> 48) + 2) >> 2);
      end
      default: res = 32768;
    endcase
    pending_q = {pending_q, res[15:0]};
  endfunction

  // Compare one result with the oldest prediction
  function void check_intensity(logic [15:0] got);
    logic [15:0] want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected intensity, expected none, actual %0d", $time, got);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (got !== want) begin
      $display("%0t: intensity mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module light_flicker_intensity_core_test;

  localparam int LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        query_valid = 1'b0;
  logic        query_stall;
  logic [2:0]  func = '0;
  logic [7:0]  period = '0;
  logic [7:0]  phase = '0;
  logic [31:0] light_index = '0;
  logic [31:0] time_ticks = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [15:0] intensity;

  intensity_board board = new();
  int  cycles = 0;
  bit  quiet = 1'b0;      // no idling in the last part
  bit  hold_off = 1'b0;   // long receiver stall requested
  int  sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  light_flicker_intensity_core u_dut (.*);

  // Count cycles and stop on timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check results as they are accepted
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_intensity(intensity);
  end

  // Drive receiver stall: random bursts, plus one long hold-off
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        result_stall <= 1'b1;
        repeat (60) @(posedge clk);
        result_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction and wait for acceptance
  task automatic send_query(logic [2:0] fx, logic [7:0] per, logic [7:0] ph,
                            logic [31:0] idx, logic [31:0] ticks);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_valid <= 1'b1;
    func <= fx;
    period <= per;
    phase <= ph;
    light_index <= idx;
    time_ticks <= ticks;
    do @(posedge clk); while (query_stall);
    board.note_query(fx, per, ph, idx, ticks);
    sent++;
  endtask

  function automatic logic [31:0] rand_ticks();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20000);
      1: return 32'hffffffff - $urandom_range(0, 5000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int wait_n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every effect, unused selectors
    for (int f = 0; f < 8; f++) send_query(3'(f), 8'd0, 8'd0, 32'd0, 32'd0);
    send_query(lfi_pkg::FX_PULSE, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff);
    send_query(lfi_pkg::FX_SUBTLE, 8'hff, 8'd64, 32'd1, 32'd5119);
    send_query(lfi_pkg::FX_PULSE, 8'd0, 8'd128, 32'd7, 32'd10);
    send_query(lfi_pkg::FX_BLINK, 8'd0, 8'd0, 32'd0, 32'd9);
    send_query(lfi_pkg::FX_BLINK, 8'd0, 8'd0, 32'd0, 32'd10);
    send_query(lfi_pkg::FX_STROBE, 8'd0, 8'd0, 32'd0, 32'd1);
    send_query(lfi_pkg::FX_STROBE, 8'd0, 8'd0, 32'd0, 32'd2);
    send_query(lfi_pkg::FX_STROBE, 8'd9, 8'd25, 32'd3, 32'd0);
    send_query(lfi_pkg::FX_STROBE, 8'd9, 8'd26, 32'd3, 32'd0);
    send_query(lfi_pkg::FX_FLICKER, 8'd0, 8'd0, 32'hffffffff, 32'hffffffff);
    send_query(lfi_pkg::FX_FLICKER, 8'hff, 8'hff, 32'h80000000, 32'd31);
    send_query(lfi_pkg::FX_FLICKER, 8'hff, 8'hff, 32'h12345678, 32'd32);
    send_query(lfi_pkg::FX_SUBTLE, 8'd1, 8'd192, 32'd9, 32'd30);

    // Random queries with a long receiver hold-off partway
    for (int i = 0; i < 400; i++) begin
      if (i == 100) hold_off = 1'b1;
      if (i == 320) quiet = 1'b1;
      send_query(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                 $urandom, rand_ticks());
    end
    query_valid <= 1'b0;

    // Drain, then allow for pipeline latency
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d light queries over all effects, selectors and field extremes;", sent);
    $display("checked %0d intensities under random gaps, stalls and a long hold-off.",
             board.checked);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
